// ----- rtl/core/lsw_pkg.sv -----
// Shared types and constants of the line-of-sight wall check.
// Holds the command word passed from the front to the back and the back's state type.
// Depends on nothing; every other file of the block imports it.
package lsw_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned IndexW = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned DiffW  = 17;
  localparam int unsigned ProdW  = 34;
  localparam int unsigned SumW   = 35;

  typedef enum logic {
    CMD_WRITE,
    CMD_QUERY
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_RESULT
  } bk_state_e;

  typedef struct packed {
    cmd_e                     op;
    logic [IndexW-1:0]        index;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
  } cmd_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
  } wall_t;

endpackage

// ----- rtl/core/lsw_front.sv -----
// Front of the line-of-sight wall check: accepts input words, classifies them
// and holds them in a two-entry queue for the back. Depends on lsw_pkg.
module lsw_front #(
  parameter int unsigned MAX_WALLS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [lsw_pkg::IndexW-1:0]    wall_index_i,
  input  logic signed [lsw_pkg::CoordW-1:0] point_a_x_i,
  input  logic signed [lsw_pkg::CoordW-1:0] point_a_y_i,
  input  logic signed [lsw_pkg::CoordW-1:0] point_b_x_i,
  input  logic signed [lsw_pkg::CoordW-1:0] point_b_y_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output lsw_pkg::cmd_t                 cmd_o
);
  import lsw_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       keep;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  // A wall write beyond the table is dropped here and never reaches the back.
  assign keep = mode_i | (32'(wall_index_i) < MAX_WALLS);

  always_comb begin
    cmd_in.op    = mode_i ? CMD_QUERY : CMD_WRITE;
    cmd_in.index = wall_index_i;
    cmd_in.ax    = point_a_x_i;
    cmd_in.ay    = point_a_y_i;
    cmd_in.bx    = point_b_x_i;
    cmd_in.by    = point_b_y_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o & keep;
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- rtl/core/lsw_back.sv -----
// Back of the line-of-sight wall check: wall table memory, scan sequencer,
// pipelined cross-product test and the output register. Depends on lsw_pkg.
module lsw_back #(
  parameter int unsigned MAX_WALLS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  lsw_pkg::cmd_t              cmd_i,
  input  logic [lsw_pkg::CountW-1:0] wall_count_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       blocked_o,
  output logic [lsw_pkg::IndexW-1:0] first_wall_o
);
  import lsw_pkg::*;

  localparam int unsigned AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int unsigned CW = $clog2(MAX_WALLS + 1);

  bk_state_e state_q, state_d;

  wall_t mem_q [MAX_WALLS];
  wall_t wall_q;

  logic signed [CoordW-1:0] ax_q, ay_q;
  logic signed [DiffW-1:0]  s2x_q, s2y_q;
  logic [CW-1:0]            n_q, cnt_q;

  logic                     v1_q, v2_q, v3_q, v4_q;
  logic [AW-1:0]            idx1_q, idx2_q, idx3_q, idx4_q;
  logic signed [DiffW-1:0]  s1x_q, s1y_q, dx_q, dy_q;
  logic signed [ProdW-1:0]  pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [SumW-1:0]   den_q, sn_q, tn_q;

  logic                     res_blocked_q;
  logic [AW-1:0]            res_idx_q;
  logic                     out_valid_q;
  logic                     blocked_q;
  logic [IndexW-1:0]        first_wall_q;

  logic signed [DiffW-1:0]  s1x_c, s1y_c, dx_c, dy_c;
  logic                     hit_c, hit4;
  logic                     mem_we, issue, load, finish, out_load;
  logic [CW-1:0]            n_c;

  assign s1x_c = DiffW'($signed(wall_q.x1)) - DiffW'($signed(wall_q.x0));
  assign s1y_c = DiffW'($signed(wall_q.y1)) - DiffW'($signed(wall_q.y0));
  assign dx_c  = DiffW'($signed(wall_q.x0)) - DiffW'(ax_q);
  assign dy_c  = DiffW'($signed(wall_q.y0)) - DiffW'(ay_q);

  always_comb begin
    if (den_q > 0) begin
      hit_c = (sn_q >= 0) && (sn_q <= den_q) && (tn_q >= 0) && (tn_q <= den_q);
    end else if (den_q < 0) begin
      hit_c = (sn_q <= 0) && (sn_q >= den_q) && (tn_q <= 0) && (tn_q >= den_q);
    end else begin
      hit_c = 1'b0;
    end
  end

  assign hit4 = v4_q & hit_c;

  always_comb begin
    if (32'(wall_count_i) > MAX_WALLS) begin
      n_c = CW'(MAX_WALLS);
    end else begin
      n_c = CW'(wall_count_i);
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    issue       = 1'b0;
    load        = 1'b0;
    finish      = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_i.op == CMD_WRITE) begin
            mem_we = 1'b1;
          end else begin
            load    = 1'b1;
            state_d = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (hit4) begin
          finish  = 1'b1;
          state_d = BK_RESULT;
        end else if (cnt_q < n_q) begin
          issue = 1'b1;
        end else if (!(v1_q || v2_q || v3_q || v4_q)) begin
          finish  = 1'b1;
          state_d = BK_RESULT;
        end
      end
      BK_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
      v1_q <= issue;
      v2_q <= v1_q & ~finish;
      v3_q <= v2_q & ~finish;
      v4_q <= v3_q & ~finish;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AW'(cmd_i.index)] <= {cmd_i.ax, cmd_i.ay, cmd_i.bx, cmd_i.by};
    end
  end

  always_ff @(posedge clk_i) begin
    wall_q <= mem_q[cnt_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ax_q  <= cmd_i.ax;
      ay_q  <= cmd_i.ay;
      s2x_q <= DiffW'(cmd_i.bx) - DiffW'(cmd_i.ax);
      s2y_q <= DiffW'(cmd_i.by) - DiffW'(cmd_i.ay);
      n_q   <= n_c;
    end
    idx1_q <= cnt_q[AW-1:0];
    idx2_q <= idx1_q;
    s1x_q  <= s1x_c;
    s1y_q  <= s1y_c;
    dx_q   <= dx_c;
    dy_q   <= dy_c;
    idx3_q <= idx2_q;
    pa_q   <= ProdW'(s1x_q) * ProdW'(s2y_q);
    pb_q   <= ProdW'(s2x_q) * ProdW'(s1y_q);
    pc_q   <= ProdW'(s1x_q) * ProdW'(dy_q);
    pd_q   <= ProdW'(s1y_q) * ProdW'(dx_q);
    pe_q   <= ProdW'(s2x_q) * ProdW'(dy_q);
    pf_q   <= ProdW'(s2y_q) * ProdW'(dx_q);
    idx4_q <= idx3_q;
    den_q  <= SumW'(pa_q) - SumW'(pb_q);
    sn_q   <= SumW'(pc_q) - SumW'(pd_q);
    tn_q   <= SumW'(pe_q) - SumW'(pf_q);
    if (finish) begin
      res_blocked_q <= hit4;
      res_idx_q     <= hit4 ? idx4_q : '0;
    end
    if (out_load) begin
      blocked_q    <= res_blocked_q;
      first_wall_q <= IndexW'(res_idx_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign blocked_o    = blocked_q;
  assign first_wall_o = first_wall_q;

endmodule

// ----- rtl/core/line_of_sight_wall_check.sv -----
// Top level of the line-of-sight wall check: configuration register and the
// front and back parts. Depends on lsw_pkg, lsw_front and lsw_back.
//
// The input channel (in_valid_i/in_ready_o) carries one word per handshake.
// Mode 0 stores a wall's endpoints at wall_index_i; mode 1 asks whether the
// segment from point A to point B crosses any of the first wall_count walls.
// Each query gives one word on the output channel (out_valid_o/out_ready_i):
// blocked_o and the index of the first wall hit, or zero when clear.
// wall_count_i is written when wall_count_we_i is high, with no wait.
// A query checks one wall per cycle through a four-stage cross-product
// pipeline fed by the table memory's read port. The back takes the next
// query only once the previous result is placed in the output register,
// and can accept it in the cycle after. Wall writes pass at one per cycle
// through a two-entry queue while the back is idle; during a query scan
// the back does not take them.
// Reset clears the count and all control state; the wall table is not
// cleared and must be written before it is queried.
// When the receiver stalls, the result is held in the output register and
// the queue keeps taking words until it is full.
module line_of_sight_wall_check #(
  parameter int unsigned MAX_WALLS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [lsw_pkg::IndexW-1:0]        wall_index_i,
  input  logic signed [lsw_pkg::CoordW-1:0] point_a_x_i,
  input  logic signed [lsw_pkg::CoordW-1:0] point_a_y_i,
  input  logic signed [lsw_pkg::CoordW-1:0] point_b_x_i,
  input  logic signed [lsw_pkg::CoordW-1:0] point_b_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              blocked_o,
  output logic [lsw_pkg::IndexW-1:0]        first_wall_o,
  input  logic                              wall_count_we_i,
  input  logic [lsw_pkg::CountW-1:0]        wall_count_i
);
  import lsw_pkg::*;

  logic [CountW-1:0] wall_count_q;
  logic              cmd_valid;
  logic              cmd_ready;
  cmd_t              cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_count_q <= '0;
    end else if (wall_count_we_i) begin
      wall_count_q <= wall_count_i;
    end
  end

  lsw_front #(
    .MAX_WALLS(MAX_WALLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .wall_index_i (wall_index_i),
    .point_a_x_i  (point_a_x_i),
    .point_a_y_i  (point_a_y_i),
    .point_b_x_i  (point_b_x_i),
    .point_b_y_i  (point_b_y_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  lsw_back #(
    .MAX_WALLS(MAX_WALLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .wall_count_i (wall_count_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .blocked_o    (blocked_o),
    .first_wall_o (first_wall_o)
  );

endmodule

// ----- rtl/core/lsw_checker.sv -----
// Port-level checks of the line-of-sight wall check and the bind that attaches
// them to the top level. Depends on lsw_pkg and line_of_sight_wall_check.
module lsw_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       blocked_o,
  input logic [lsw_pkg::IndexW-1:0] first_wall_o
);
  import lsw_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(blocked_o) && $stable(first_wall_o))
    else $error("Output word changed while stalled.");

  a_clear_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !blocked_o |-> first_wall_o == '0)
    else $error("Unblocked result carries a nonzero wall index.");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("Result word shown right after reset.");

  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_o, out_valid_o}))
    else $error("Handshake output is unknown.");

endmodule

bind line_of_sight_wall_check lsw_checker u_lsw_checker (.*);

// ----- tb/sv/line_of_sight_wall_check_tb.sv -----
`timescale 1ns / 100ps
// Testbench for line_of_sight_wall_check: directed geometry cases, then random wall and query
// traffic, checked against a built-in predictor of the wall scan. Depends on lsw_pkg and the RTL.
module line_of_sight_wall_check_tb;

  import lsw_pkg::*;

  localparam int unsigned NumWalls      = 64;
  localparam int unsigned SettleCycles  = 80;
  localparam int unsigned WatchdogLimit = 1000;

  typedef struct packed {
    logic              blocked;
    logic [IndexW-1:0] first_wall;
  } sight_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  cmd_e                     mode = CMD_WRITE;
  logic [IndexW-1:0]        wall_index = '0;
  logic signed [CoordW-1:0] point_a_x = '0;
  logic signed [CoordW-1:0] point_a_y = '0;
  logic signed [CoordW-1:0] point_b_x = '0;
  logic signed [CoordW-1:0] point_b_y = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     blocked;
  logic [IndexW-1:0]        first_wall;
  logic                     count_we = 1'b0;
  logic [CountW-1:0]        count_val = '0;

  wall_t             wall_shadow [NumWalls];
  logic [CountW-1:0] count_shadow = '0;
  sight_t            sight_q [$];
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;
  bit                tx_idle_en = 1'b1;
  bit                rx_idle_en = 1'b1;

  line_of_sight_wall_check #(
    .MAX_WALLS(NumWalls)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .wall_index_i   (wall_index),
    .point_a_x_i    (point_a_x),
    .point_a_y_i    (point_a_y),
    .point_b_x_i    (point_b_x),
    .point_b_y_i    (point_b_y),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .blocked_o      (blocked),
    .first_wall_o   (first_wall),
    .wall_count_we_i(count_we),
    .wall_count_i   (count_val)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic wall_t seg(input int x0, input int y0, input int x1, input int y1);
    wall_t s;
    s.x0 = 16'(x0);
    s.y0 = 16'(y0);
    s.x1 = 16'(x1);
    s.y1 = 16'(y1);
    return s;
  endfunction

  function automatic bit segments_cross(input wall_t w, input wall_t q);
    longint s1x, s1y, s2x, s2y, dx, dy, den, sn, tn;
    s1x = longint'($signed(w.x1)) - longint'($signed(w.x0));
    s1y = longint'($signed(w.y1)) - longint'($signed(w.y0));
    s2x = longint'($signed(q.x1)) - longint'($signed(q.x0));
    s2y = longint'($signed(q.y1)) - longint'($signed(q.y0));
    dx  = longint'($signed(w.x0)) - longint'($signed(q.x0));
    dy  = longint'($signed(w.y0)) - longint'($signed(q.y0));
    den = s1x * s2y - s2x * s1y;
    sn  = s1x * dy - s1y * dx;
    tn  = s2x * dy - s2y * dx;
    if (den > 0) begin
      return sn >= 0 && sn <= den && tn >= 0 && tn <= den;
    end else if (den < 0) begin
      return sn <= 0 && sn >= den && tn <= 0 && tn >= den;
    end
    return 1'b0;
  endfunction

  function automatic sight_t predict_sight(input wall_t q);
    sight_t      res;
    int unsigned n;
    res = '0;
    n = (count_shadow > NumWalls) ? NumWalls : count_shadow;
    for (int unsigned i = 0; i < n && !res.blocked; i++) begin
      if (segments_cross(wall_shadow[i], q)) begin
        res.blocked    = 1'b1;
        res.first_wall = IndexW'(i);
      end
    end
    return res;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord(input int unsigned style);
    case (style)
      0: rand_coord = CoordW'($urandom());
      1: rand_coord = CoordW'(int'($urandom_range(0, 128)) - 64);
      default: begin
        case ($urandom_range(0, 3))
          0: rand_coord = 16'sh8000;
          1: rand_coord = 16'sh7fff;
          2: rand_coord = -16'sd1;
          default: rand_coord = '0;
        endcase
      end
    endcase
  endfunction

  function automatic wall_t random_points(input int unsigned style);
    wall_t s;
    s.x0 = rand_coord(style);
    s.y0 = rand_coord(style);
    s.x1 = rand_coord(style);
    s.y1 = rand_coord(style);
    return s;
  endfunction

  function automatic wall_t random_wall();
    wall_t       s;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      s = random_points(0);
    end else if (r == 2) begin
      s = random_points(2);
    end else begin
      s = random_points(1);
      if (r == 3) begin
        s.x1 = s.x0;
      end else if (r == 4) begin
        s.y1 = s.y0;
      end
    end
    return s;
  endfunction

  function automatic wall_t random_query();
    wall_t       s;
    wall_t       w;
    int unsigned r;
    logic signed [CoordW-1:0] ox, oy;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      s = random_points(0);
    end else if (r == 1) begin
      s = random_points(2);
    end else if (r < 4) begin
      // Shifted copy of a stored wall: parallel, or collinear when the shift runs along the wall (as when it is zero).
      w  = wall_shadow[$urandom_range(0, NumWalls - 1)];
      ox = CoordW'(int'($urandom_range(0, 4)) - 2);
      oy = CoordW'(int'($urandom_range(0, 4)) - 2);
      s.x0 = w.x0 + ox;
      s.y0 = w.y0 + oy;
      s.x1 = w.x1 + ox;
      s.y1 = w.y1 + oy;
    end else begin
      s = random_points(1);
    end
    return s;
  endfunction

  task automatic send_word(input cmd_e op, input logic [IndexW-1:0] idx, input wall_t pts);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid   <= 1'b1;
    mode       <= op;
    wall_index <= idx;
    point_a_x  <= pts.x0;
    point_a_y  <= pts.y0;
    point_b_x  <= pts.x1;
    point_b_y  <= pts.y1;
    do @(posedge clk_i); while (!in_ready);
    if (op == CMD_WRITE) begin
      wall_shadow[idx] = pts;
    end else begin
      sight_q.push_back(predict_sight(pts));
    end
  endtask

  task automatic send_query(input wall_t pts);
    send_word(CMD_QUERY, IndexW'($urandom()), pts);
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sight_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_wall_count(input logic [CountW-1:0] n);
    @(negedge clk_i);
    count_we  <= 1'b1;
    count_val <= n;
    @(negedge clk_i);
    count_we  <= 1'b0;
    count_shadow = n;
  endtask

  task automatic test_empty_count();
    send_query(seg(-32768, -32768, 32767, 32767));
  endtask

  task automatic test_basic_geometry();
    send_word(CMD_WRITE, 6'd0, seg(-100, 50, 100, 50));
    send_word(CMD_WRITE, 6'd1, seg(0, -100, 0, 100));
    send_word(CMD_WRITE, 6'd2, seg(-32768, -32768, 32767, 32767));
    send_word(CMD_WRITE, 6'd3, seg(10, 10, 20, 20));
    send_word(CMD_WRITE, 6'd4, seg(5, 5, 5, 5));
    send_word(CMD_WRITE, 6'd5, seg(-32768, 32767, 32767, -32768));
    wait_for_drain();
    set_wall_count(7'd6);
    send_query(seg(-50, 0, 50, 0));
    send_query(seg(200, -200, 300, -100));
    send_query(seg(1000, 1000, 2000, 1100));
  endtask

  task automatic test_endpoint_touch();
    send_query(seg(-100, 50, -100, 80));
    send_query(seg(30, 50, 30, 90));
    send_query(seg(-32768, 32767, 32767, 32767));
    send_query(seg(-32768, -32768, 32767, -32768));
  endtask

  task automatic test_parallel_walls();
    send_query(seg(12, 12, 18, 18));
    send_query(seg(-100, 50, 100, 50));
    send_query(seg(5, 5, 5, 5));
  endtask

  task automatic test_count_limits();
    wait_for_drain();
    set_wall_count(7'd1);
    send_query(seg(-50, 0, 50, 0));
    send_query(seg(-10, 40, 10, 60));
    wait_for_drain();
    set_wall_count(7'd3);
    send_query(seg(200, -200, 300, -100));
  endtask

  task automatic test_random_traffic();
    logic [CountW-1:0] counts [7];
    wall_t             pts;
    counts = '{7'd64, 7'd127, 7'd1, 7'd0, CountW'($urandom_range(2, 63)),
               CountW'($urandom_range(65, 126)), 7'd64};
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int unsigned i = 0; i < NumWalls; i++) begin
      send_word(CMD_WRITE, IndexW'(i), random_wall());
    end
    for (int unsigned p = 0; p < 7; p++) begin
      wait_for_drain();
      set_wall_count(counts[p]);
      tx_idle_en = (p != 0) && (p != 4);
      rx_idle_en = (p != 0) && (p != 5);
      for (int unsigned k = 0; k < 62; k++) begin
        if (p == 2 && k == 31) begin
          wait_for_drain();
        end
        if ($urandom_range(0, 9) < 7) begin
          send_query(random_query());
        end else begin
          pts = random_wall();
          send_word(CMD_WRITE, IndexW'($urandom_range(0, NumWalls - 1)), pts);
        end
      end
    end
  endtask

  initial begin : receiver
    int unsigned w;
    wait (rst_ni);
    forever begin
      w = rx_idle_en ? $urandom_range(0, 4) : 0;
      if (w != 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (w - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk_i) begin : check_results
    sight_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (sight_q.size() == 0) begin
        $error("unexpected result word: blocked %0d, first_wall %0d", blocked, first_wall);
        mismatch_count++;
      end else begin
        want = sight_q.pop_front();
        if (blocked !== want.blocked) begin
          $error("blocked: expected %0d, actual %0d", want.blocked, blocked);
          mismatch_count++;
        end
        if (first_wall !== want.first_wall) begin
          $error("first_wall: expected %0d, actual %0d", want.first_wall, first_wall);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || count_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_count();
    test_basic_geometry();
    test_endpoint_touch();
    test_parallel_walls();
    test_count_limits();
    test_random_traffic();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lsw_pkg.sv
rtl/core/lsw_front.sv
rtl/core/lsw_back.sv
rtl/core/line_of_sight_wall_check.sv
rtl/core/lsw_checker.sv
tb/sv/line_of_sight_wall_check_tb.sv
